// File: rtl/isotp_pkg.sv
// Shared types and constants for the ISO 8601 timestamp parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package isotp_pkg;

    localparam int EPOCH_W  = 39;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 40;

    // ASCII codes the parser looks for
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_Z     = 8'h5A;

    // One parsed text, handed from the character parser to the arithmetic
    // pipe. Field values are meaningful only when ok is set.
    typedef struct packed {
        logic       ok;
        logic [6:0] year_hi;
        logic [6:0] year_lo;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic       off_neg;
        logic [4:0] off_hour;
        logic [5:0] off_minute;
    } job_t;

endpackage

// File: rtl/iso_timestamp_parser.sv
// Top level of the ISO 8601 timestamp parser: parser, job queue, arithmetic pipe.
// Depends on isotp_pkg, isotp_front, isotp_fifo, isotp_back.
`timescale 1ns / 1ps

// Usage:
//   Slave stream carries the text, one character per beat: s_tdata[7:0] is the
//   ASCII byte and s_tlast marks the final character. Only the final beat of a
//   text produces a result on the master stream: m_tdata[38:0] holds UTC epoch
//   seconds (two's complement, zero when invalid) and m_tuser is the valid flag.
//   Throughput: one character per cycle, with no gaps between texts, while s_tready is high.
//   After its final character is taken, a text passes through the job queue,
//   then the four-stage arithmetic pipe and the output register.
//   Up to FIFO_DEPTH finished texts wait in the job queue, plus five in the
//   pipe; s_tready drops only when the queue is full, so a stalled receiver
//   holds the result on m_tdata/m_tuser and input continues until then.
//   Reset clears the parser back to the first character and empties the queue
//   and the pipe; no result is pending after reset.
module iso_timestamp_parser
    import isotp_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [7:0] char_code
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [38:0] epoch_seconds, [39] zero
    output logic                m_tuser    // [0] valid_res
);

    logic               beat;
    logic               push;
    job_t               wr_job, rd_job;
    logic               pop, empty, full;
    logic [EPOCH_W-1:0] epoch_seconds;

    assign s_tready = !full;
    assign beat     = s_tvalid && s_tready;

    isotp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (beat),
        .char_code (s_tdata),
        .last_char (s_tlast),
        .push      (push),
        .job       (wr_job)
    );

    isotp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (wr_job),
        .pop    (pop),
        .rd_job (rd_job),
        .empty  (empty),
        .full   (full)
    );

    isotp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (!empty),
        .job           (rd_job),
        .job_pop       (pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .epoch_seconds (epoch_seconds),
        .valid_res     (m_tuser)
    );

    assign m_tdata = {1'b0, epoch_seconds};

endmodule

// File: rtl/isotp_front.sv
// Character parser: walks the text one beat at a time and checks it.
// On the final character it emits one job_t; depends on isotp_pkg.
`timescale 1ns / 1ps

module isotp_front
    import isotp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] char_code,
    input  logic       last_char,
    output logic       push,
    output job_t       job
);

    typedef enum logic [2:0] {
        PH_MAIN    = 3'd0,
        PH_SEC_END = 3'd1,
        PH_DOT     = 3'd2,
        PH_FRAC    = 3'd3,
        PH_ZULU    = 3'd4,
        PH_OFFSET  = 3'd5
    } phase_t;

    function automatic logic [6:0] acc10(input logic [6:0] acc, input logic [3:0] v);
        acc10 = 7'({acc, 3'b000} + {acc, 1'b0} + 10'(v));
    endfunction

    function automatic logic [6:0] month_days(input logic [6:0] m, input logic leap);
        case (m)
            7'd4, 7'd6, 7'd9, 7'd11: month_days = 7'd30;
            7'd2:                    month_days = leap ? 7'd29 : 7'd28;
            default:                 month_days = 7'd31;
        endcase
    endfunction

    function automatic logic fields_ok(
        input logic [6:0] yhi, input logic [6:0] ylo, input logic [6:0] m,
        input logic [6:0] d,   input logic [6:0] h,   input logic [6:0] mi,
        input logic [6:0] s
    );
        logic leap;
        leap = (ylo[1:0] == 2'd0 && ylo != 7'd0) || (ylo == 7'd0 && yhi[1:0] == 2'd0);
        fields_ok = (m >= 7'd1) && (m <= 7'd12) && (d >= 7'd1) && (d <= month_days(m, leap))
                    && (h <= 7'd23) && (mi <= 7'd59) && (s <= 7'd59);
    endfunction

    logic [4:0] idx_reg, idx_next;
    phase_t     phase_reg, phase_next;
    logic       failed_reg, failed_next;
    logic [6:0] yhi_reg, yhi_next, ylo_reg, ylo_next;
    logic [6:0] mon_reg, mon_next, day_reg, day_next;
    logic [6:0] hr_reg, hr_next, mi_reg, mi_next, sec_reg, sec_next;
    logic       oneg_reg, oneg_next;
    logic [6:0] ohr_reg, ohr_next, omi_reg, omi_next;
    logic [2:0] ocnt_reg, ocnt_next;
    logic       ocolon_reg, ocolon_next;

    logic       digit;
    logic [3:0] dval;
    logic       ok;

    assign digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign dval  = char_code[3:0];

    always_comb
    begin
        idx_next    = idx_reg;
        phase_next  = phase_reg;
        failed_next = failed_reg;
        yhi_next    = yhi_reg;
        ylo_next    = ylo_reg;
        mon_next    = mon_reg;
        day_next    = day_reg;
        hr_next     = hr_reg;
        mi_next     = mi_reg;
        sec_next    = sec_reg;
        oneg_next   = oneg_reg;
        ohr_next    = ohr_reg;
        omi_next    = omi_reg;
        ocnt_next   = ocnt_reg;
        ocolon_next = ocolon_reg;

        if (!failed_reg)
        begin
            case (phase_reg)
                PH_MAIN:
                begin
                    if (idx_reg == 5'd4 || idx_reg == 5'd7)
                    begin
                        if (char_code != CH_DASH) failed_next = 1'b1;
                    end
                    else if (idx_reg == 5'd10)
                    begin
                        if (char_code != CH_T && char_code != CH_SPACE) failed_next = 1'b1;
                    end
                    else if (idx_reg == 5'd13 || idx_reg == 5'd16)
                    begin
                        if (char_code != CH_COLON) failed_next = 1'b1;
                    end
                    else if (!digit) failed_next = 1'b1;
                    else if (idx_reg <= 5'd1)  yhi_next = acc10(yhi_reg, dval);
                    else if (idx_reg <= 5'd3)  ylo_next = acc10(ylo_reg, dval);
                    else if (idx_reg <= 5'd6)  mon_next = acc10(mon_reg, dval);
                    else if (idx_reg <= 5'd9)  day_next = acc10(day_reg, dval);
                    else if (idx_reg <= 5'd12) hr_next  = acc10(hr_reg, dval);
                    else if (idx_reg <= 5'd15) mi_next  = acc10(mi_reg, dval);
                    else                       sec_next = acc10(sec_reg, dval);

                    if (idx_reg >= 5'd18)
                    begin
                        phase_next = PH_SEC_END;
                        if (!fields_ok(yhi_next, ylo_next, mon_next, day_next,
                                       hr_next, mi_next, sec_next))
                            failed_next = 1'b1;
                    end
                    if (idx_reg != 5'd31) idx_next = idx_reg + 5'd1;
                end
                PH_SEC_END, PH_FRAC:
                begin
                    if (phase_reg == PH_SEC_END && char_code == CH_DOT) phase_next = PH_DOT;
                    else if (phase_reg == PH_FRAC && digit) phase_next = PH_FRAC;
                    else if (char_code == CH_Z) phase_next = PH_ZULU;
                    else if (char_code == CH_PLUS || char_code == CH_DASH)
                    begin
                        phase_next = PH_OFFSET;
                        oneg_next  = (char_code == CH_DASH);
                    end
                    else failed_next = 1'b1;
                end
                PH_DOT:
                begin
                    if (digit) phase_next = PH_FRAC;
                    else failed_next = 1'b1;
                end
                PH_OFFSET:
                begin
                    if (digit && ocnt_reg < 3'd4)
                    begin
                        if (ocnt_reg < 3'd2) ohr_next = acc10(ohr_reg, dval);
                        else                 omi_next = acc10(omi_reg, dval);
                        ocnt_next = ocnt_reg + 3'd1;
                    end
                    else if (char_code == CH_COLON && ocnt_reg == 3'd2 && !ocolon_reg)
                        ocolon_next = 1'b1;
                    else failed_next = 1'b1;
                end
                default: failed_next = 1'b1;
            endcase
        end

        ok = !failed_next && phase_next != PH_MAIN && phase_next != PH_DOT
             && (phase_next != PH_OFFSET
                 || (ocnt_next == 3'd4 && ohr_next <= 7'd23 && omi_next <= 7'd59));
    end

    assign push           = in_valid && last_char;
    assign job.ok         = ok;
    assign job.year_hi    = yhi_next;
    assign job.year_lo    = ylo_next;
    assign job.month      = mon_next[3:0];
    assign job.day        = day_next[4:0];
    assign job.hour       = hr_next[4:0];
    assign job.minute     = mi_next[5:0];
    assign job.second     = sec_next[5:0];
    assign job.off_neg    = oneg_next;
    assign job.off_hour   = ohr_next[4:0];
    assign job.off_minute = omi_next[5:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            phase_reg  <= PH_MAIN;
            failed_reg <= 1'b0;
            yhi_reg    <= '0;
            ylo_reg    <= '0;
            mon_reg    <= '0;
            day_reg    <= '0;
            hr_reg     <= '0;
            mi_reg     <= '0;
            sec_reg    <= '0;
            oneg_reg   <= 1'b0;
            ohr_reg    <= '0;
            omi_reg    <= '0;
            ocnt_reg   <= '0;
            ocolon_reg <= 1'b0;
        end
        else if (in_valid)
        begin
            if (last_char)
            begin
                idx_reg    <= '0;
                phase_reg  <= PH_MAIN;
                failed_reg <= 1'b0;
                yhi_reg    <= '0;
                ylo_reg    <= '0;
                mon_reg    <= '0;
                day_reg    <= '0;
                hr_reg     <= '0;
                mi_reg     <= '0;
                sec_reg    <= '0;
                oneg_reg   <= 1'b0;
                ohr_reg    <= '0;
                omi_reg    <= '0;
                ocnt_reg   <= '0;
                ocolon_reg <= 1'b0;
            end
            else
            begin
                idx_reg    <= idx_next;
                phase_reg  <= phase_next;
                failed_reg <= failed_next;
                yhi_reg    <= yhi_next;
                ylo_reg    <= ylo_next;
                mon_reg    <= mon_next;
                day_reg    <= day_next;
                hr_reg     <= hr_next;
                mi_reg     <= mi_next;
                sec_reg    <= sec_next;
                oneg_reg   <= oneg_next;
                ohr_reg    <= ohr_next;
                omi_reg    <= omi_next;
                ocnt_reg   <= ocnt_next;
                ocolon_reg <= ocolon_next;
            end
        end
    end

endmodule

// File: rtl/isotp_fifo.sv
// Small job queue between the parser and the arithmetic pipe.
// Register-based, first-word fall-through; depends on isotp_pkg.
`timescale 1ns / 1ps

module isotp_fifo
    import isotp_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t wr_job,
    input  logic pop,
    output job_t rd_job,
    output logic empty,
    output logic full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == FULL_CNT);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_job  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push) mem[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push) wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)      count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push) count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// File: rtl/isotp_back.sv
// Arithmetic pipe: turns a checked date/time/offset into epoch seconds.
// Four stages plus the output register; depends on isotp_pkg.
`timescale 1ns / 1ps

module isotp_back
    import isotp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    input  job_t               job,
    output logic               job_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [EPOCH_W-1:0] epoch_seconds,
    output logic               valid_res
);

    // days from March 1 to the first of each month
    function automatic logic [8:0] month_base(input logic [3:0] m);
        case (m)
            4'd1:    month_base = 9'd306;
            4'd2:    month_base = 9'd337;
            4'd3:    month_base = 9'd0;
            4'd4:    month_base = 9'd31;
            4'd5:    month_base = 9'd61;
            4'd6:    month_base = 9'd92;
            4'd7:    month_base = 9'd122;
            4'd8:    month_base = 9'd153;
            4'd9:    month_base = 9'd184;
            4'd10:   month_base = 9'd214;
            4'd11:   month_base = 9'd245;
            4'd12:   month_base = 9'd275;
            default: month_base = 9'd0;
        endcase
    endfunction

    localparam logic [23:0] DAY_BIAS = 24'd865565;

    logic adv;

    logic               s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, out_v_reg;
    logic               s1_ok_reg, s2_ok_reg, s3_ok_reg, s4_ok_reg;
    logic [13:0]        s1_yy_reg, s2_yy_reg;
    logic [8:0]         s1_doy_reg, s2_doy_reg;
    logic signed [18:0] s1_tod_reg, s2_tod_reg, s3_tod_reg, s4_tod_reg;
    logic [6:0]         s2_q100_reg;
    logic signed [23:0] s3_days_reg;
    logic [39:0]        s4_prod_reg;
    logic [EPOCH_W-1:0] out_epoch_reg;
    logic               out_ok_reg;

    logic [13:0]        s1_year_next, s1_yy_next;
    logic [8:0]         s1_doy_next;
    logic [16:0]        tod, off;
    logic signed [18:0] s1_tod_next;
    logic [26:0]        q_prod;
    logic [23:0]        s3_days_next;
    logic signed [40:0] s4_prod_full;
    logic [39:0]        sum;

    assign adv     = !out_v_reg || out_ready;
    assign job_pop = adv && job_valid;

    always_comb
    begin
        s1_year_next = 14'(job.year_hi) * 14'd100 + 14'(job.year_lo);
        s1_yy_next   = s1_year_next + 14'd400 - ((job.month <= 4'd2) ? 14'd1 : 14'd0);
        s1_doy_next  = month_base(job.month) + 9'(job.day) - 9'd1;
        tod          = 17'(job.hour) * 17'd3600 + 17'(job.minute) * 17'd60 + 17'(job.second);
        off          = 17'(job.off_hour) * 17'd3600 + 17'(job.off_minute) * 17'd60;
        s1_tod_next  = job.off_neg ? $signed({2'b00, tod}) + $signed({2'b00, off})
                                   : $signed({2'b00, tod}) - $signed({2'b00, off});

        // floor(yy / 100) by reciprocal, exact for yy below 43699
        q_prod = 27'(s1_yy_reg) * 27'd5243;

        s3_days_next = 24'(s2_yy_reg) * 24'd365 + 24'(s2_yy_reg >> 2) - 24'(s2_q100_reg)
                       + 24'(s2_q100_reg >> 2) + 24'(s2_doy_reg) - DAY_BIAS;

        s4_prod_full = 41'(s3_days_reg) * 41'sd86400;

        sum = s4_prod_reg + 40'(s4_tod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg  <= job_valid;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            s4_v_reg  <= s3_v_reg;
            out_v_reg <= s4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ok_reg     <= job.ok;
            s1_yy_reg     <= s1_yy_next;
            s1_doy_reg    <= s1_doy_next;
            s1_tod_reg    <= s1_tod_next;

            s2_ok_reg     <= s1_ok_reg;
            s2_yy_reg     <= s1_yy_reg;
            s2_doy_reg    <= s1_doy_reg;
            s2_tod_reg    <= s1_tod_reg;
            s2_q100_reg   <= q_prod[25:19];

            s3_ok_reg     <= s2_ok_reg;
            s3_tod_reg    <= s2_tod_reg;
            s3_days_reg   <= $signed(s3_days_next);

            s4_ok_reg     <= s3_ok_reg;
            s4_tod_reg    <= s3_tod_reg;
            s4_prod_reg   <= s4_prod_full[39:0];

            out_ok_reg    <= s4_ok_reg;
            out_epoch_reg <= s4_ok_reg ? sum[EPOCH_W-1:0] : '0;
        end
    end

    assign out_valid     = out_v_reg;
    assign epoch_seconds = out_epoch_reg;
    assign valid_res     = out_ok_reg;

endmodule

// File: sim/tb_iso_timestamp_parser.sv
// Self-checking testbench for iso_timestamp_parser: streams timestamp texts,
// predicts epoch seconds and valid flag per text, checks every result beat.
// Depends on isotp_pkg and the RTL of iso_timestamp_parser.
`timescale 1ns / 1ps

module tb_iso_timestamp_parser;

    import isotp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef enum logic [2:0] {
        PH_MAIN,
        PH_TIME_DONE,
        PH_DOT,
        PH_FRAC,
        PH_ZULU,
        PH_OFFSET
    } phase_t;

    typedef struct packed {
        logic [EPOCH_W-1:0] secs;
        logic               ok;
    } stamp_result_t;

    typedef logic [7:0] text_t[$];

    logic                clk;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tlast  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;

    stamp_result_t expected_stamps[$];
    int            error_count = 0;
    int            cycle_count = 0;
    int            chars_sent  = 0;
    int            texts_sent  = 0;
    int            calm_left   = 0;
    int            rdy_hold    = 0;

    // predictor state
    logic [4:0]  ps_index     = '0;
    phase_t      ps_phase     = PH_MAIN;
    logic        ps_bad       = 1'b0;
    logic [13:0] ps_year      = '0;
    logic [6:0]  ps_month     = '0;
    logic [6:0]  ps_day       = '0;
    logic [6:0]  ps_hour      = '0;
    logic [6:0]  ps_min       = '0;
    logic [6:0]  ps_sec       = '0;
    logic        ps_off_neg   = 1'b0;
    logic [13:0] ps_off_val   = '0;
    logic [2:0]  ps_off_cnt   = '0;
    logic        ps_off_colon = 1'b0;

    iso_timestamp_parser DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int month_len(input int y, input int m);
        bit leap;
        leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        case (m)
            2:           return leap ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    // days since 1970-01-01, year shifted by one 400-year cycle to stay positive
    function automatic longint day_number(input int y, input int m, input int d);
        longint yr;
        longint era;
        longint yoe;
        longint doy;
        longint doe;
        int     mp;
        yr  = longint'(y) + 400 - ((m <= 2) ? 1 : 0);
        era = yr / 400;
        yoe = yr - era * 400;
        mp  = (m > 2) ? m - 3 : m + 9;
        doy = longint'((153 * mp + 2) / 5 + d - 1);
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * 146097 + doe - 719468 - 146097;
    endfunction

    function automatic text_t to_text(input string s);
        text_t t;
        for (int i = 0; i < s.len(); i++)
            t.push_back(s[i]);
        return t;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        error_count++;
    endtask

    task parse_char(input logic [7:0] c, input logic last);
        logic          digit;
        logic [7:0]    v;
        logic          ok;
        longint        secs;
        longint        off;
        stamp_result_t res;
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        v     = c - CH_ZERO;
        if (!ps_bad)
        begin
            if (ps_phase == PH_MAIN)
            begin
                if (ps_index == 5'd4 || ps_index == 5'd7)
                begin
                    if (c != CH_DASH) ps_bad = 1'b1;
                end
                else if (ps_index == 5'd10)
                begin
                    if (c != CH_T && c != CH_SPACE) ps_bad = 1'b1;
                end
                else if (ps_index == 5'd13 || ps_index == 5'd16)
                begin
                    if (c != CH_COLON) ps_bad = 1'b1;
                end
                else if (!digit)            ps_bad   = 1'b1;
                else if (ps_index <= 5'd3)  ps_year  = 14'(ps_year * 10 + v);
                else if (ps_index <= 5'd6)  ps_month = 7'(ps_month * 10 + v);
                else if (ps_index <= 5'd9)  ps_day   = 7'(ps_day * 10 + v);
                else if (ps_index <= 5'd12) ps_hour  = 7'(ps_hour * 10 + v);
                else if (ps_index <= 5'd15) ps_min   = 7'(ps_min * 10 + v);
                else                        ps_sec   = 7'(ps_sec * 10 + v);
                if (ps_index >= 5'd18)
                begin
                    ps_phase = PH_TIME_DONE;
                    if (ps_month < 7'd1 || ps_month > 7'd12)
                        ps_bad = 1'b1;
                    else if (ps_day < 7'd1
                             || int'(ps_day) > month_len(int'(ps_year), int'(ps_month)))
                        ps_bad = 1'b1;
                    else if (ps_hour > 7'd23 || ps_min > 7'd59 || ps_sec > 7'd59)
                        ps_bad = 1'b1;
                end
                if (ps_index != 5'd31) ps_index = ps_index + 5'd1;
            end
            else
            begin
                case (ps_phase)
                    PH_TIME_DONE, PH_FRAC:
                    begin
                        if (ps_phase == PH_TIME_DONE && c == CH_DOT)
                            ps_phase = PH_DOT;
                        else if (ps_phase == PH_FRAC && digit)
                            ps_phase = PH_FRAC;
                        else if (c == CH_Z)
                            ps_phase = PH_ZULU;
                        else if (c == CH_PLUS || c == CH_DASH)
                        begin
                            ps_phase   = PH_OFFSET;
                            ps_off_neg = (c == CH_DASH);
                        end
                        else
                            ps_bad = 1'b1;
                    end
                    PH_DOT:
                    begin
                        if (digit) ps_phase = PH_FRAC;
                        else       ps_bad   = 1'b1;
                    end
                    PH_OFFSET:
                    begin
                        if (digit && ps_off_cnt < 3'd4)
                        begin
                            ps_off_val = 14'(ps_off_val * 10 + v);
                            ps_off_cnt = ps_off_cnt + 3'd1;
                        end
                        else if (c == CH_COLON && ps_off_cnt == 3'd2 && !ps_off_colon)
                            ps_off_colon = 1'b1;
                        else
                            ps_bad = 1'b1;
                    end
                    default:
                        ps_bad = 1'b1;
                endcase
            end
        end
        if (last)
        begin
            ok   = !ps_bad && ps_phase != PH_MAIN && ps_phase != PH_DOT;
            secs = 0;
            if (ok && ps_phase == PH_OFFSET)
            begin
                if (ps_off_cnt != 3'd4 || ps_off_val / 100 > 23 || ps_off_val % 100 > 59)
                    ok = 1'b0;
            end
            if (ok)
            begin
                secs = day_number(int'(ps_year), int'(ps_month), int'(ps_day)) * 86400
                     + longint'(ps_hour) * 3600 + longint'(ps_min) * 60 + longint'(ps_sec);
                if (ps_phase == PH_OFFSET)
                begin
                    off  = longint'(ps_off_val / 100) * 3600
                         + longint'(ps_off_val % 100) * 60;
                    secs = ps_off_neg ? secs + off : secs - off;
                end
            end
            res.secs = secs[EPOCH_W-1:0];
            res.ok   = ok;
            expected_stamps.push_back(res);
            ps_index     = '0;
            ps_phase     = PH_MAIN;
            ps_bad       = 1'b0;
            ps_year      = '0;
            ps_month     = '0;
            ps_day       = '0;
            ps_hour      = '0;
            ps_min       = '0;
            ps_sec       = '0;
            ps_off_neg   = 1'b0;
            ps_off_val   = '0;
            ps_off_cnt   = '0;
            ps_off_colon = 1'b0;
        end
    endtask

    // result check first, then feed the accepted character to the predictor
    always @(posedge clk)
    begin : beat_monitor
        stamp_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_stamps.size() == 0)
                    report_mismatch("result beat with no text pending");
                else
                begin
                    want = expected_stamps.pop_front();
                    if (m_tdata[EPOCH_W-1:0] !== want.secs)
                        report_mismatch($sformatf("epoch got %0d exp %0d",
                            $signed(m_tdata[EPOCH_W-1:0]), $signed(want.secs)));
                    if (m_tdata[M_DATA_W-1] !== 1'b0)
                        report_mismatch("tdata pad bit not zero");
                    if (m_tuser !== want.ok)
                        report_mismatch($sformatf("valid got %b exp %b", m_tuser, want.ok));
                end
            end
            if (s_tvalid && s_tready)
                parse_char(s_tdata, s_tlast);
        end
    end

    always @(posedge clk)
    begin : ready_gen
        int r;
        if (rdy_hold > 0)
            rdy_hold = rdy_hold - 1;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                m_tready <= 1'b1;
                rdy_hold = $urandom_range(0, 7);
            end
            else if (r < 85)
            begin
                m_tready <= 1'b0;
                rdy_hold = $urandom_range(0, 2);
            end
            else if (r < 95)
            begin
                m_tready <= 1'b1;
                rdy_hold = $urandom_range(20, 80);
            end
            else
            begin
                m_tready <= 1'b0;
                rdy_hold = $urandom_range(10, 25);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        int r;
        gap = 0;
        if (calm_left > 0)
            calm_left--;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
                calm_left = $urandom_range(20, 60);
            else if (r >= 60 && r < 92)
                gap = $urandom_range(1, 3);
            else if (r >= 92)
                gap = $urandom_range(8, 30);
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_text(input text_t t);
        for (int i = 0; i < t.size(); i++)
            send_char(t[i], i == t.size() - 1);
        texts_sent++;
    endtask

    function automatic text_t make_stamp();
        int    y, mo, d, h, mi, se, oh, om, flaw, tail, pos;
        string s, sep, sign;
        text_t t;
        case ($urandom_range(0, 3))
            0:       y = $urandom_range(0, 9999);
            1:       y = $urandom_range(1900, 2100);
            2:       y = $urandom_range(0, 99) * 100;
            default: y = ($urandom_range(0, 1) != 0) ? 9999 : 0;
        endcase
        mo = $urandom_range(1, 12);
        if ($urandom_range(0, 3) == 0) d = month_len(y, mo);
        else                           d = $urandom_range(1, month_len(y, mo));
        h    = $urandom_range(0, 23);
        mi   = $urandom_range(0, 59);
        se   = $urandom_range(0, 59);
        oh   = $urandom_range(0, 23);
        om   = $urandom_range(0, 59);
        flaw = $urandom_range(0, 11);
        tail = (flaw == 8) ? $urandom_range(2, 3) : $urandom_range(0, 3);
        if (flaw == 8)
        begin
            case ($urandom_range(0, 7))
                0:       mo = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(13, 99);
                1:       d  = 0;
                2:       d  = month_len(y, mo) + 1;
                3:       h  = $urandom_range(24, 99);
                4:       mi = $urandom_range(60, 99);
                5:       se = $urandom_range(60, 99);
                6:       oh = $urandom_range(24, 99);
                default: om = $urandom_range(60, 99);
            endcase
        end
        sep = "T";
        if ($urandom_range(0, 1) != 0) sep = " ";
        sign = "+";
        if ($urandom_range(0, 1) != 0) sign = "-";
        s = $sformatf("%04d-%02d-%02d%s%02d:%02d:%02d", y, mo, d, sep, h, mi, se);
        if ($urandom_range(0, 2) == 0)
        begin
            s = {s, "."};
            repeat ($urandom_range(1, 5)) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
        end
        case (tail)
            1:       s = {s, "Z"};
            2:       s = {s, $sformatf("%s%02d%02d", sign, oh, om)};
            3:       s = {s, $sformatf("%s%02d:%02d", sign, oh, om)};
            default: ;
        endcase
        t = to_text(s);
        case (flaw)
            9:
            begin
                pos    = $urandom_range(0, t.size() - 1);
                t[pos] = 8'($urandom_range(0, 255));
            end
            10: t = t[0:$urandom_range(0, t.size() - 2)];
            11:
            begin
                case ($urandom_range(0, 4))
                    0:       t.push_back(CH_DOT);
                    1:       t.push_back(CH_COLON);
                    2:       t.push_back(CH_Z);
                    3:       t.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                    default: t.push_back(8'($urandom_range(0, 255)));
                endcase
            end
            default: ;
        endcase
        return t;
    endfunction

    task automatic test_directed();
        string cases[$] = {
            "1970-01-01T00:00:00",
            "0000-01-01T00:00:00+23:59",
            "9999-12-31 23:59:59-23:59",
            "2000-02-29T12:34:56.789Z",
            "2024-02-29T23:59:59.5+05:30",
            "1900-02-29T00:00:00",
            "2023-04-31T00:00:00",
            "2023-13-01T00:00:00",
            "2023-00-10T00:00:00Z",
            "2023-01-00T00:00:00",
            "2023-01-01T24:00:00",
            "2023-01-01T23:60:00",
            "2023-01-01T23:59:60",
            "2023-01-01T10:00:00.",
            "2023-01-01T10:00:00.Z",
            "2023-01-01T10:00:00-0000",
            "2023-01-01T10:00:00+05:3",
            "2023-01-01T10:00:00+053:0",
            "2023-01-01T10:00:00+05:30:",
            "2023-01-01T10:00:00+2400",
            "2023-01-01T10:00:00+0060",
            "2023-01-01T10:00:00+05301",
            "2023-01-01T10:00:00ZZ",
            "2023-01-01T10:00:0",
            "2023-01-01t10:00:00",
            "2023/01-01T10:00:00",
            "2023-01-01T10:00:0/",
            "2023-01-01T10:00:0:",
            "X"
        };
        text_t t;
        foreach (cases[i])
            send_text(to_text(cases[i]));
        t    = to_text("2023-01-01T10:00:00");
        t[2] = 8'hFF;
        send_text(t);
    endtask

    task automatic test_random_stamps();
        while (chars_sent < 660 || texts_sent < 33)
            send_text(make_stamp());
    endtask

    task automatic test_noise();
        text_t t;
        repeat (3)
        begin
            t.delete();
            repeat ($urandom_range(1, 12)) t.push_back(8'($urandom_range(0, 255)));
            send_text(t);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_stamps();
        test_noise();
        s_tvalid <= 1'b0;
        while (expected_stamps.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
